// ===== hdl/overwriting_ring_deque_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the overwriting ring deque
// Shared helpers so each check reads as one line.
// ----------------------------------------------------------------------------
`ifndef OVERWRITING_RING_DEQUE_CORE_DEFINES_SVH
`define OVERWRITING_RING_DEQUE_CORE_DEFINES_SVH

// Clocked check, disabled while reset is asserted
`define ORD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset
`define ORD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/ord_pkg.sv =====
// ----------------------------------------------------------------------------
// ord_pkg
// Shared widths, codes and defaults of the overwriting ring deque.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ord_pkg;

  localparam int unsigned VAL_W       = 31;
  localparam int unsigned OFF_W       = 8;
  localparam int unsigned PTR_W       = 8;
  localparam int unsigned SIZE_W      = 9;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam int unsigned DEPTH_DEFAULT = 256;
  localparam int unsigned SIZE_CAP      = 256;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_REMOVE     = 3'd6,
    OP_LENGTH     = 3'd7
  } op_e;

endpackage

// ===== hdl/ord_mod_unit.sv =====
// ----------------------------------------------------------------------------
// ord_mod_unit
// Bit-serial restoring remainder: dividend mod divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ord_mod_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ord_pkg::OFF_W-1:0]      dividend_i,
  input  logic [ord_pkg::PTR_W-1:0]      divisor_i,
  output logic                           done_o,
  output logic [ord_pkg::PTR_W-1:0]      rem_o
);

  localparam int unsigned CntW = $clog2(ord_pkg::OFF_W);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [ord_pkg::PTR_W-1:0]   rem_q, rem_d;
  logic [ord_pkg::OFF_W-1:0]   dvd_q, dvd_d;
  logic [ord_pkg::PTR_W-1:0]   div_q, div_d;
  logic [ord_pkg::PTR_W:0]     trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    trial  = {rem_q, dvd_q[ord_pkg::OFF_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      rem_d = trial[ord_pkg::PTR_W-1:0];
      dvd_d = {dvd_q[ord_pkg::OFF_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(ord_pkg::OFF_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== hdl/overwriting_ring_deque_core.sv =====
// ----------------------------------------------------------------------------
// overwriting_ring_deque_core
// Double-ended queue in a ring of slots that overwrites the far end when full.
// ----------------------------------------------------------------------------
// One transaction is worked at a time; the slot memory has a single port with
// a registered read. From input acceptance to a result in the output register:
// push, length and a pop, peek or remove on an empty queue pass the execute
// state, pop and peek add one memory read, and remove runs the bit-serial
// remainder unit, then a read of the removed slot, a read of the front entry
// and its write-back. A new input is taken while the previous result still
// waits on the output. A ring of S slots holds at most S-1 entries; writing
// the size register empties the queue.
`timescale 1ns / 1ps

module overwriting_ring_deque_core #(
  parameter int unsigned DEPTH = ord_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // operation [2:0], value [33:3], offset [41:34], zero [47:42]
  input  logic [ord_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // entry_value [30:0], found [31], dropped [32], length [40:33], zero [47:41]
  output logic [ord_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [ord_pkg::SIZE_W-1:0]          cfg_data_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o
);

  localparam int unsigned MemDepth = (DEPTH < ord_pkg::SIZE_CAP) ? DEPTH : ord_pkg::SIZE_CAP;
  localparam int unsigned AW       = $clog2(MemDepth);
  localparam logic [ord_pkg::SIZE_W-1:0] SizeTop = ord_pkg::SIZE_W'(MemDepth);

  typedef logic [ord_pkg::PTR_W-1:0]  ptr_t;
  typedef logic [ord_pkg::SIZE_W-1:0] size_t;
  typedef logic [ord_pkg::VAL_W-1:0]  val_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_RDWAIT, ST_DIV, ST_RM1, ST_RM2, ST_DONE
  } state_e;

  function automatic ptr_t ring_inc(ptr_t p, size_t s);
    size_t t;
    t = {1'b0, p} + 1'b1;
    return (t == s) ? '0 : t[ord_pkg::PTR_W-1:0];
  endfunction

  function automatic ptr_t ring_dec(ptr_t p, size_t s);
    size_t t;
    t = s - 1'b1;
    return (p == '0) ? t[ord_pkg::PTR_W-1:0] : p - 1'b1;
  endfunction

  function automatic ptr_t held(ptr_t f, ptr_t b, size_t s);
    size_t t;
    if (f >= b) t = {1'b0, f} - {1'b0, b};
    else        t = {1'b0, f} + s - {1'b0, b};
    return t[ord_pkg::PTR_W-1:0];
  endfunction

  state_e          state_q, state_d;
  ord_pkg::op_e    op_q, op_d;
  val_t            val_q, val_d;
  logic [ord_pkg::OFF_W-1:0] off_q, off_d;
  ptr_t            front_q, front_d;
  ptr_t            back_q, back_d;
  size_t           size_q, size_d;
  ptr_t            pos_q, pos_d;
  val_t            res_q, res_d;
  logic            found_q, found_d;
  logic            dropped_q, dropped_d;
  logic            out_valid_q, out_valid_d;
  logic [ord_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;

  val_t            mem_q [MemDepth];
  val_t            rd_q;
  logic            mem_we, mem_re;
  ptr_t            mem_ptr;
  val_t            mem_wdata;

  logic            div_start, div_done;
  ptr_t            div_rem;
  ptr_t            len;
  ptr_t            f_inc, f_dec, b_inc, b_dec;
  size_t           pos_sum, size_clamp;

  ord_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (off_q),
    .divisor_i  (len),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign len   = held(front_q, back_q, size_q);
  assign f_inc = ring_inc(front_q, size_q);
  assign f_dec = ring_dec(front_q, size_q);
  assign b_inc = ring_inc(back_q, size_q);
  assign b_dec = ring_dec(back_q, size_q);

  always_comb begin
    if (cfg_data_i < size_t'(2)) size_clamp = size_t'(2);
    else if (cfg_data_i > SizeTop) size_clamp = SizeTop;
    else size_clamp = cfg_data_i;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    off_d       = off_q;
    front_d     = front_q;
    back_d      = back_q;
    size_d      = size_q;
    pos_d       = pos_q;
    res_d       = res_q;
    found_d     = found_q;
    dropped_d   = dropped_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_ptr     = front_q;
    mem_wdata   = val_q;
    div_start   = 1'b0;
    pos_sum     = {1'b0, back_q} + {1'b0, div_rem};

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d      = ord_pkg::op_e'(s_axis_tdata[2:0]);
          val_d     = s_axis_tdata[33:3];
          off_d     = s_axis_tdata[41:34];
          res_d     = '0;
          found_d   = 1'b0;
          dropped_d = 1'b0;
          state_d   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        case (op_q)
          ord_pkg::OP_PUSH_FRONT: begin
            mem_we  = 1'b1;
            mem_ptr = front_q;
            front_d = f_inc;
            if (f_inc == back_q) begin
              back_d    = b_inc;
              dropped_d = 1'b1;
            end
          end
          ord_pkg::OP_PUSH_BACK: begin
            mem_we  = 1'b1;
            mem_ptr = b_dec;
            back_d  = b_dec;
            if (front_q == b_dec) begin
              front_d   = f_dec;
              dropped_d = 1'b1;
            end
          end
          ord_pkg::OP_POP_FRONT, ord_pkg::OP_PEEK_FRONT: begin
            if (len != '0) begin
              mem_re  = 1'b1;
              mem_ptr = f_dec;
              found_d = 1'b1;
              state_d = ST_RDWAIT;
              if (op_q == ord_pkg::OP_POP_FRONT) front_d = f_dec;
            end
          end
          ord_pkg::OP_POP_BACK, ord_pkg::OP_PEEK_BACK: begin
            if (len != '0) begin
              mem_re  = 1'b1;
              mem_ptr = back_q;
              found_d = 1'b1;
              state_d = ST_RDWAIT;
              if (op_q == ord_pkg::OP_POP_BACK) back_d = b_inc;
            end
          end
          ord_pkg::OP_REMOVE: begin
            if (len != '0) begin
              div_start = 1'b1;
              found_d   = 1'b1;
              state_d   = ST_DIV;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_RDWAIT: begin
        res_d   = rd_q;
        state_d = ST_DONE;
      end
      ST_DIV: begin
        if (div_done) begin
          // back + (offset mod len) stays below twice the ring size
          if (pos_sum >= size_q) pos_sum = pos_sum - size_q;
          pos_d   = pos_sum[ord_pkg::PTR_W-1:0];
          mem_re  = 1'b1;
          mem_ptr = pos_sum[ord_pkg::PTR_W-1:0];
          state_d = ST_RM1;
        end
      end
      ST_RM1: begin
        res_d   = rd_q;
        mem_re  = 1'b1;
        mem_ptr = f_dec;
        state_d = ST_RM2;
      end
      ST_RM2: begin
        // front-most entry fills the freed slot; same slot is a plain pop
        mem_we    = 1'b1;
        mem_ptr   = pos_q;
        mem_wdata = rd_q;
        front_d   = f_dec;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {7'd0, len, dropped_q, found_q, res_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_valid_i) begin
      size_d  = size_clamp;
      front_d = size_clamp[ord_pkg::SIZE_W-1:1];
      back_d  = size_clamp[ord_pkg::SIZE_W-1:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= SizeTop[ord_pkg::SIZE_W-1:1];
      back_q      <= SizeTop[ord_pkg::SIZE_W-1:1];
      size_q      <= SizeTop;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      back_q      <= back_d;
      size_q      <= size_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    val_q      <= val_d;
    off_q      <= off_d;
    pos_q      <= pos_d;
    res_q      <= res_d;
    found_q    <= found_d;
    dropped_q  <= dropped_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_ptr[AW-1:0]] <= mem_wdata;
    if (mem_re) rd_q <= mem_q[mem_ptr[AW-1:0]];
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

endmodule

// ===== hdl/ord_checker.sv =====
// ----------------------------------------------------------------------------
// ord_checker
// Port-level checks of the overwriting ring deque, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "overwriting_ring_deque_core_defines.svh"

module ord_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic [ord_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready
);

  `ORD_ASSERT_RST(a_no_result_in_reset, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

  `ORD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  `ORD_ASSERT(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while busy")

  `ORD_ASSERT(a_found_xor_dropped, m_axis_tvalid |-> !(m_axis_tdata[31] && m_axis_tdata[32]), "found and dropped together")

  `ORD_ASSERT(a_empty_value, m_axis_tvalid && !m_axis_tdata[31] |-> m_axis_tdata[30:0] == '0, "value without a find")

endmodule

bind overwriting_ring_deque_core ord_checker u_ord_checker (.*);
